// File: rtl/dagrc_pkg.sv
// ----------------------------------------------------------------------------
// dagrc_pkg
// Shared constants, types and helpers for the DAG reach counter.
// ----------------------------------------------------------------------------
package dagrc_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int FIFO_D    = 4;
  localparam int FIFO_AW   = $clog2(FIFO_D);

  // one queued edge transaction, already range checked
  typedef struct packed {
    logic              edge_ok;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic              last;
  } edge_item_t;

  // clamp the node count register to 1 .. MAX_NODES
  function automatic logic [CNT_W-1:0] eff_nodes(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    if (v > CNT_W'(MAX_NODES)) r = CNT_W'(MAX_NODES);
    return r;
  endfunction

  // index of the lowest set bit (zero when none)
  function automatic logic [NODE_W-1:0] lowest_idx(input logic [MAX_NODES-1:0] v);
    logic [MAX_NODES-1:0] oh;
    logic [NODE_W-1:0]    r;
    oh = v & (~v + MAX_NODES'(1));
    r  = '0;
    for (int j = 0; j < MAX_NODES; j++) begin
      if (oh[j]) r = r | NODE_W'(j);
    end
    return r;
  endfunction

endpackage

// File: rtl/dagrc_ram.sv
// ----------------------------------------------------------------------------
// dagrc_ram
// Single-port RAM, bit write mask, registered read.
// ----------------------------------------------------------------------------
module dagrc_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] addr_i,
  input  logic [W-1:0]         wmask_i,
  input  logic [W-1:0]         wdata_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < W; b++) begin
        if (wmask_i[b]) mem[addr_i][b] <= wdata_i[b];
      end
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// File: rtl/dagrc_front.sv
// ----------------------------------------------------------------------------
// dagrc_front
// Accepts edge transactions, range checks them and queues them.
// ----------------------------------------------------------------------------
module dagrc_front
  import dagrc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CNT_W-1:0]  nodes_i,
  input  logic              start_i,
  input  logic              edge_valid_i,
  input  logic [NODE_W-1:0] src_node_i,
  input  logic [NODE_W-1:0] dst_node_i,
  input  logic              last_edge_i,
  output logic              busy_o,
  output logic              item_vld_o,
  output edge_item_t        item_o,
  input  logic              item_pop_i,
  input  logic              done_i
);

  edge_item_t        fifo_q [FIFO_D];
  logic [FIFO_AW-1:0] wp_q, rp_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               closing_q;
  logic               push;
  edge_item_t         in_item;

  // hold off while the queue is full, and after the closing item until its results are out
  assign busy_o = closing_q || (cnt_q == (FIFO_AW+1)'(FIFO_D));
  assign push   = start_i && !busy_o;

  always_comb begin
    in_item.edge_ok = edge_valid_i && ({1'b0, src_node_i} < nodes_i)
                      && ({1'b0, dst_node_i} < nodes_i);
    in_item.src     = src_node_i;
    in_item.dst     = dst_node_i;
    in_item.last    = last_edge_i;
  end

  assign item_vld_o = (cnt_q != '0);
  assign item_o     = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= in_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      rp_q      <= '0;
      cnt_q     <= '0;
      closing_q <= 1'b0;
    end else begin
      if (push) wp_q <= wp_q + FIFO_AW'(1);
      if (item_pop_i) rp_q <= rp_q + FIFO_AW'(1);
      cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(item_pop_i);
      if (push && last_edge_i) closing_q <= 1'b1;
      else if (done_i) closing_q <= 1'b0;
    end
  end

endmodule

// File: rtl/dagrc_back.sv
// ----------------------------------------------------------------------------
// dagrc_back
// Loads the adjacency matrix, runs Kahn ordering, reverse closure and
// emits one reach count per node.
// ----------------------------------------------------------------------------
module dagrc_back
  import dagrc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CNT_W-1:0]  nodes_i,
  input  logic              item_vld_i,
  input  edge_item_t        item_i,
  output logic              item_pop_o,
  output logic              done_o,
  output logic              result_valid_o,
  output logic [NODE_W-1:0] node_index_o,
  output logic [CNT_W-1:0]  reach_count_o,
  output logic              last_result_o
);

  typedef enum logic [3:0] {
    S_EDGE, S_SW, S_INIT, S_PUSH, S_POP_A, S_POP_B, S_POP_C,
    S_CL_A, S_CL_B, S_CL_C, S_CL_D, S_CL_E, S_OUT_A, S_OUT_B
  } state_e;

  state_e state_q;

  logic [MAX_NODES-1:0] row_valid_q, ordered_q, pend_q, succ_q, acc_q;
  logic [CNT_W-1:0]     deg_q [MAX_NODES];
  logic [CNT_W-1:0]     i_q, head_q, tail_q, k_q, j_q;
  logic                 sw_vld_q;
  logic [NODE_W-1:0]    sw_idx_q, x_q, adj_ra_q;
  logic [MAX_NODES-1:0] nmask, adj_row;

  // RAM ports
  logic                 adj_we, rch_we, ord_we, cnt_we;
  logic [NODE_W-1:0]    adj_addr, rch_addr, ord_addr, cnt_addr;
  logic [MAX_NODES-1:0] adj_wmask, adj_wdata, adj_rdata, rch_wdata, rch_rdata;
  logic [NODE_W-1:0]    ord_wdata, ord_rdata;
  logic [CNT_W-1:0]     cnt_wdata, cnt_rdata;
  logic [CNT_W-1:0]     k_m1;

  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) nmask[j] = (CNT_W'(j) < nodes_i);
  end

  // rows never written since the last clear read as zero
  assign adj_row = (row_valid_q[adj_ra_q] ? adj_rdata : '0) & nmask;
  assign k_m1    = k_q - CNT_W'(1);
  assign item_pop_o = (state_q == S_EDGE) && item_vld_i;

  always_comb begin
    adj_we = 1'b0; adj_addr = '0;
    adj_wdata = MAX_NODES'(1) << item_i.dst;
    adj_wmask = row_valid_q[item_i.src] ? adj_wdata : '1;
    rch_we = 1'b0; rch_addr = '0; rch_wdata = acc_q;
    ord_we = 1'b0; ord_addr = '0; ord_wdata = lowest_idx(pend_q);
    cnt_we = 1'b0; cnt_addr = '0; cnt_wdata = CNT_W'($countones(acc_q));
    unique case (state_q)
      S_EDGE: begin
        adj_addr = item_i.src;
        adj_we   = item_vld_i && item_i.edge_ok;
      end
      S_SW: begin
        adj_addr  = i_q[NODE_W-1:0];
        rch_addr  = sw_idx_q;
        rch_we    = sw_vld_q;
        rch_wdata = adj_row | (MAX_NODES'(1) << sw_idx_q);
      end
      S_PUSH: begin
        ord_addr = tail_q[NODE_W-1:0];
        ord_we   = (pend_q != '0);
      end
      S_POP_A: ord_addr = head_q[NODE_W-1:0];
      S_POP_B, S_CL_B: adj_addr = ord_rdata;
      S_CL_A: ord_addr = k_m1[NODE_W-1:0];
      S_CL_D: begin
        if (succ_q != '0) begin
          rch_addr = lowest_idx(succ_q);
        end else begin
          rch_addr = x_q;
          rch_we   = 1'b1;
          cnt_addr = x_q;
          cnt_we   = 1'b1;
        end
      end
      S_OUT_A: cnt_addr = j_q[NODE_W-1:0];
      default: ;
    endcase
  end

  dagrc_ram #(.W(MAX_NODES), .D(MAX_NODES)) u_adj (
    .clk_i, .we_i(adj_we), .addr_i(adj_addr), .wmask_i(adj_wmask),
    .wdata_i(adj_wdata), .rdata_o(adj_rdata));
  dagrc_ram #(.W(MAX_NODES), .D(MAX_NODES)) u_reach (
    .clk_i, .we_i(rch_we), .addr_i(rch_addr), .wmask_i('1),
    .wdata_i(rch_wdata), .rdata_o(rch_rdata));
  dagrc_ram #(.W(NODE_W), .D(MAX_NODES)) u_order (
    .clk_i, .we_i(ord_we), .addr_i(ord_addr), .wmask_i('1),
    .wdata_i(ord_wdata), .rdata_o(ord_rdata));
  dagrc_ram #(.W(CNT_W), .D(MAX_NODES)) u_count (
    .clk_i, .we_i(cnt_we), .addr_i(cnt_addr), .wmask_i('1),
    .wdata_i(cnt_wdata), .rdata_o(cnt_rdata));

  // payload lanes
  always_ff @(posedge clk_i) begin
    adj_ra_q <= adj_addr;
    unique case (state_q)
      S_EDGE: begin
        for (int j = 0; j < MAX_NODES; j++) deg_q[j] <= '0;
      end
      S_SW: begin
        if (sw_vld_q) begin
          for (int j = 0; j < MAX_NODES; j++) deg_q[j] <= deg_q[j] + CNT_W'(adj_row[j]);
        end
      end
      S_POP_C: begin
        for (int j = 0; j < MAX_NODES; j++) begin
          if (adj_row[j] && deg_q[j] != '0) deg_q[j] <= deg_q[j] - CNT_W'(1);
        end
      end
      default: ;
    endcase
    if (state_q == S_POP_B || state_q == S_CL_B) x_q <= ord_rdata;
    if (state_q == S_CL_C) begin
      succ_q <= adj_row;
      acc_q  <= adj_row | (MAX_NODES'(1) << x_q);
    end
    if (state_q == S_CL_D && succ_q != '0)
      succ_q <= succ_q & ~(MAX_NODES'(1) << lowest_idx(succ_q));
    if (state_q == S_CL_E) acc_q <= acc_q | rch_rdata;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_EDGE;
      row_valid_q    <= '0;
      ordered_q      <= '0;
      pend_q         <= '0;
      i_q            <= '0;
      head_q         <= '0;
      tail_q         <= '0;
      k_q            <= '0;
      j_q            <= '0;
      sw_vld_q       <= 1'b0;
      sw_idx_q       <= '0;
      done_o         <= 1'b0;
      result_valid_o <= 1'b0;
      node_index_o   <= '0;
      reach_count_o  <= '0;
      last_result_o  <= 1'b0;
    end else begin
      done_o         <= 1'b0;
      result_valid_o <= 1'b0;
      unique case (state_q)
        S_EDGE: begin
          if (item_vld_i) begin
            if (item_i.edge_ok) row_valid_q[item_i.src] <= 1'b1;
            if (item_i.last) begin
              state_q   <= S_SW;
              i_q       <= '0;
              sw_vld_q  <= 1'b0;
              ordered_q <= '0;
              head_q    <= '0;
              tail_q    <= '0;
            end
          end
        end
        S_SW: begin
          sw_vld_q <= (i_q < nodes_i);
          sw_idx_q <= i_q[NODE_W-1:0];
          if (i_q < nodes_i) i_q <= i_q + CNT_W'(1);
          else if (!sw_vld_q) state_q <= S_INIT;
        end
        S_INIT: begin
          for (int j = 0; j < MAX_NODES; j++) pend_q[j] <= nmask[j] && (deg_q[j] == '0);
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (pend_q != '0) begin
            pend_q[lowest_idx(pend_q)]    <= 1'b0;
            ordered_q[lowest_idx(pend_q)] <= 1'b1;
            tail_q <= tail_q + CNT_W'(1);
          end else if (head_q != tail_q) begin
            state_q <= S_POP_A;
          end else begin
            k_q     <= tail_q;
            state_q <= (tail_q != '0) ? S_CL_A : S_OUT_A;
            j_q     <= '0;
          end
        end
        S_POP_A: begin
          head_q  <= head_q + CNT_W'(1);
          state_q <= S_POP_B;
        end
        S_POP_B: state_q <= S_POP_C;
        S_POP_C: begin
          for (int j = 0; j < MAX_NODES; j++) begin
            if (adj_row[j] && deg_q[j] == CNT_W'(1)) pend_q[j] <= 1'b1;
          end
          state_q <= S_PUSH;
        end
        S_CL_A: begin
          k_q     <= k_m1;
          state_q <= S_CL_B;
        end
        S_CL_B: state_q <= S_CL_C;
        S_CL_C: state_q <= S_CL_D;
        S_CL_D: begin
          if (succ_q != '0) state_q <= S_CL_E;
          else state_q <= (k_q == '0) ? S_OUT_A : S_CL_A;
        end
        S_CL_E: state_q <= S_CL_D;
        S_OUT_A: state_q <= S_OUT_B;
        S_OUT_B: begin
          result_valid_o <= 1'b1;
          node_index_o   <= j_q[NODE_W-1:0];
          reach_count_o  <= ordered_q[j_q[NODE_W-1:0]] ? cnt_rdata : '0;
          last_result_o  <= (j_q + CNT_W'(1) == nodes_i);
          j_q            <= j_q + CNT_W'(1);
          if (j_q + CNT_W'(1) == nodes_i) begin
            done_o      <= 1'b1;
            row_valid_q <= '0;
            state_q     <= S_EDGE;
          end else begin
            state_q <= S_OUT_A;
          end
        end
        default: state_q <= S_EDGE;
      endcase
    end
  end

  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("ready queue head passed tail");
  a_tail_le_nodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= CNT_W'(MAX_NODES)) else $error("more nodes ordered than exist");
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_result_o |-> row_valid_q == '0 && $past(done_o == 1'b0))
    else $error("matrix not cleared with last result");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> !result_valid_o || last_result_o)
    else $error("edge taken during result burst");

endmodule

// File: rtl/dag_reachable_node_count_top.sv
// ----------------------------------------------------------------------------
// dag_reachable_node_count_top
// Per-node reachable node count of a directed graph via Kahn ordering.
// ----------------------------------------------------------------------------
//  channel   | signals                                           | handshake
//  ----------+---------------------------------------------------+------------------
//  edge in   | edge_valid_i src_node_i dst_node_i last_edge_i    | start && !busy
//  config    | cfg_data_i (node_count)                           | cfg_valid_i/ready
//  result    | node_index_o reach_count_o last_result_o          | result_valid_o
//
//  Edge transactions are taken one per cycle, while busy is low, into a 4-deep
//  queue; in its edge state the back end writes one matrix row bit per cycle
//  through the adjacency RAM port. After the closing transaction it sweeps the
//  in-degrees, takes each ordered node from the ready queue and frees its
//  successors, runs the reverse closure, then emits results in node order.
//  busy stays high from the closing transaction until the last result.
//  Reset is asynchronous, active low, and leaves the matrix empty.
//  The receiver cannot stall: each result shows for one cycle.
// ----------------------------------------------------------------------------
module dag_reachable_node_count_top
  import dagrc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              edge_valid_i,
  input  logic [NODE_W-1:0] src_node_i,
  input  logic [NODE_W-1:0] dst_node_i,
  input  logic              last_edge_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CNT_W-1:0]  cfg_data_i,
  output logic              result_valid_o,
  output logic [NODE_W-1:0] node_index_o,
  output logic [CNT_W-1:0]  reach_count_o,
  output logic              last_result_o
);

  logic [CNT_W-1:0] node_count_q;
  logic [CNT_W-1:0] nodes;
  logic             item_vld, item_pop, done;
  edge_item_t       item;

  assign cfg_ready_o = 1'b1;
  assign nodes       = eff_nodes(node_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CNT_W'(MAX_NODES);
    end else if (cfg_valid_i && cfg_ready_o) begin
      node_count_q <= cfg_data_i;
    end
  end

  // front: range check and queue
  dagrc_front u_front (
    .clk_i, .rst_ni, .nodes_i(nodes), .start_i(start),
    .edge_valid_i, .src_node_i, .dst_node_i, .last_edge_i,
    .busy_o(busy), .item_vld_o(item_vld), .item_o(item),
    .item_pop_i(item_pop), .done_i(done));

  // back: matrix, ordering, closure, results
  dagrc_back u_back (
    .clk_i, .rst_ni, .nodes_i(nodes), .item_vld_i(item_vld), .item_i(item),
    .item_pop_o(item_pop), .done_o(done), .result_valid_o,
    .node_index_o, .reach_count_o, .last_result_o);

endmodule
